// ===== sv/dcmr_pkg.sv =====
// Shared widths, register indexes, reset values and control phase codes.
package dcmr_pkg;

  // Widths of the data path
  localparam int DUTY_BITS  = 10;
  localparam int COUNT_BITS = 16;
  localparam int STEP_W     = 10;
  localparam int INTV_W     = 8;
  localparam int WIN_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int PULSE_W    = 4;
  localparam int SPEED_W    = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // Sum width for the duty ramp adder
  localparam int SUM_W = ((DUTY_BITS > STEP_W) ? DUTY_BITS : STEP_W) + 1;
  // Product and divider widths for the speed meter
  localparam int PROD_W = SCALE_W + COUNT_BITS;
  localparam int ITER_W = $clog2(PROD_W);

  // Stream word widths, rounded up to whole bytes
  localparam int IN_W         = DUTY_BITS + 1 + PULSE_W;
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W        = DUTY_BITS + 3 + SPEED_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 2'd3;

  // Configuration reset values
  localparam logic [STEP_W-1:0]  RST_RAMP_STEP     = STEP_W'(50);
  localparam logic [INTV_W-1:0]  RST_RAMP_INTERVAL = INTV_W'(20);
  localparam logic [WIN_W-1:0]   RST_SPEED_WINDOW  = WIN_W'(100);
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE   = SCALE_W'(1000);

  // Control phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_TRACK = 2'd1;
  localparam logic [1:0] PH_DOWN  = 2'd2;
  localparam logic [1:0] PH_UP    = 2'd3;

endpackage

// ===== sv/dc_motor_duty_ramp_reverser.sv =====
// DC motor duty ramp with soft direction reversal and windowed speed meter.
//
// Usage: each input word on the s_axis channel is one control tick holding
// the target duty, target direction and encoder pulses of that tick. Every
// accepted word yields exactly one output word on the m_axis channel with the
// driven duty and direction, driver enable, ramp-reached flag, last speed and
// a flag that marks a fresh speed value.
// Sequence: the tick is evaluated in the cycle after acceptance (ST_CALC), and
// the result passes through ST_DONE into the output register; a tick that
// closes the speed window first goes through ST_MUL for the multiply and
// ST_DIV, where the shared restoring divider forms all PROD_W (32) quotient
// bits. One word is in work at a time: a new tick is taken after ST_DONE.
// The output register decouples the sides: while a result waits for
// m_axis_tready the block still takes and evaluates the next tick, and holds
// that result until the output register frees up.
// Configuration words go through cfg_we_i / cfg_idx_i / cfg_wdata_i, one
// register per write, while the block is idle: a user rule, not enforced.
// Reset (rst_ni low, asynchronous) restores the register defaults, puts the
// controller in its start phase with zero duty and saturates the ramp timer
// so the first ramp step fires on the first tick.
module dc_motor_duty_ramp_reverser
  import dcmr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // Input tick stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: target_duty, target_dir, encoder_pulses (lowest bit first)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Output result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: duty_out, dir_out, drive_enable, ramp_reached, speed_value,
  //        speed_valid (lowest bit first)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [STEP_W-1:0]  ramp_step_q;
  logic [INTV_W-1:0]  ramp_interval_q;
  logic [WIN_W-1:0]   speed_window_q;
  logic [SCALE_W-1:0] speed_scale_q;

  // Controller state
  logic [1:0]           phase_q, phase_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic                 cur_dir_q, cur_dir_d;
  logic                 drv_dir_q, drv_dir_d;
  logic [INTV_W-1:0]    ramp_timer_q, ramp_timer_d;
  logic [WIN_W-1:0]     win_timer_q, win_timer_d;
  logic [COUNT_BITS-1:0] pulse_cnt_q, pulse_cnt_d;
  logic [SPEED_W-1:0]   speed_q;
  logic                 reached_q, reached_d;
  logic                 valid_q, valid_d;

  // Captured input word
  logic [DUTY_BITS-1:0] tgt_duty_q;
  logic                 tgt_dir_q;
  logic [PULSE_W-1:0]   pulses_q;

  // Shared multiply / divide unit
  logic [COUNT_BITS-1:0] mul_cnt_q;
  logic [WIN_W-1:0]      divisor_q;
  logic [PROD_W-1:0]     quo_q;
  logic [WIN_W:0]        rem_q;
  logic [ITER_W-1:0]     iter_q;

  // Output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Ramp and phase evaluation for the captured tick
  logic [INTV_W-1:0]    timer_inc;
  logic                 do_ramp;
  logic [DUTY_BITS-1:0] goal;
  logic                 rdir;
  logic                 fire;
  logic                 hit;
  logic [SUM_W-1:0]     up_sum;
  logic [SUM_W-1:0]     down_lim;
  logic [DUTY_BITS-1:0] ramp_duty;

  always_comb begin
    timer_inc = (ramp_timer_q != '1) ? ramp_timer_q + 1'b1 : ramp_timer_q;
    do_ramp   = 1'b0;
    goal      = tgt_duty_q;
    rdir      = cur_dir_q;
    case (phase_q)
      PH_START: do_ramp = 1'b1;
      PH_TRACK: do_ramp = (duty_q != tgt_duty_q);
      PH_DOWN: begin
        do_ramp = 1'b1;
        goal    = '0;
      end
      PH_UP: begin
        do_ramp = 1'b1;
        rdir    = ~cur_dir_q;
      end
      default: do_ramp = 1'b0;
    endcase
    fire     = do_ramp && (timer_inc >= ramp_interval_q);
    up_sum   = SUM_W'(duty_q) + SUM_W'(ramp_step_q);
    down_lim = SUM_W'(goal) + SUM_W'(ramp_step_q);
    // Move toward the goal, clamp on overshoot
    if (duty_q < goal) begin
      hit       = (up_sum >= SUM_W'(goal));
      ramp_duty = hit ? goal : up_sum[DUTY_BITS-1:0];
    end else begin
      hit       = (SUM_W'(duty_q) <= down_lim);
      ramp_duty = hit ? goal : DUTY_BITS'(SUM_W'(duty_q) - SUM_W'(ramp_step_q));
    end
  end

  // Window bookkeeping for the captured tick
  logic [COUNT_BITS-1:0] cnt_sum;
  logic [WIN_W-1:0]      win_inc;
  logic                  win_close;

  always_comb begin
    cnt_sum   = pulse_cnt_q + COUNT_BITS'(pulses_q);
    win_inc   = win_timer_q + 1'b1;
    if (win_inc == '0) begin
      win_inc = WIN_W'(1);
    end
    win_close = (win_inc >= speed_window_q);
  end

  // Divider step and speed saturation
  logic [WIN_W:0]        rem_sh;
  logic                  q_bit;
  logic [WIN_W:0]        rem_nx;
  logic [PROD_W+31:0]    quo_ext;
  logic [SPEED_W-1:0]    speed_sat;

  always_comb begin
    rem_sh  = {rem_q[WIN_W-1:0], quo_q[PROD_W-1]};
    q_bit   = (rem_sh >= {1'b0, divisor_q});
    rem_nx  = q_bit ? rem_sh - {1'b0, divisor_q} : rem_sh;
    quo_ext = {32'b0, {quo_q[PROD_W-2:0], q_bit}};
    speed_sat = (|quo_ext[PROD_W+31:32]) ? '1 : quo_ext[31:0];
  end

  // Sequencer and controller next state
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    duty_d       = duty_q;
    cur_dir_d    = cur_dir_q;
    drv_dir_d    = drv_dir_q;
    ramp_timer_d = ramp_timer_q;
    win_timer_d  = win_timer_q;
    pulse_cnt_d  = pulse_cnt_q;
    reached_d    = reached_q;
    valid_d      = valid_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        reached_d = fire && hit;
        if (fire) begin
          duty_d       = ramp_duty;
          drv_dir_d    = rdir;
          ramp_timer_d = '0;
        end else begin
          ramp_timer_d = timer_inc;
        end
        case (phase_q)
          PH_START: phase_d = PH_TRACK;
          PH_TRACK: begin
            if (!do_ramp && (cur_dir_q != tgt_dir_q)) begin
              phase_d = PH_DOWN;
            end
          end
          PH_DOWN: begin
            if (fire && hit) begin
              phase_d = PH_UP;
            end
          end
          PH_UP: begin
            if (fire && hit) begin
              cur_dir_d = ~cur_dir_q;
              phase_d   = PH_TRACK;
            end
          end
          default: phase_d = phase_q;
        endcase
        valid_d = win_close;
        if (win_close) begin
          pulse_cnt_d = '0;
          win_timer_d = '0;
          state_d     = ST_MUL;
        end else begin
          pulse_cnt_d = cnt_sum;
          win_timer_d = win_inc;
          state_d     = ST_DONE;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (iter_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      phase_q         <= PH_START;
      duty_q          <= '0;
      cur_dir_q       <= 1'b0;
      drv_dir_q       <= 1'b0;
      ramp_timer_q    <= '1;
      win_timer_q     <= '0;
      pulse_cnt_q     <= '0;
      speed_q         <= '0;
      reached_q       <= 1'b0;
      valid_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      ramp_step_q     <= RST_RAMP_STEP;
      ramp_interval_q <= RST_RAMP_INTERVAL;
      speed_window_q  <= RST_SPEED_WINDOW;
      speed_scale_q   <= RST_SPEED_SCALE;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      duty_q       <= duty_d;
      cur_dir_q    <= cur_dir_d;
      drv_dir_q    <= drv_dir_d;
      ramp_timer_q <= ramp_timer_d;
      win_timer_q  <= win_timer_d;
      pulse_cnt_q  <= pulse_cnt_d;
      reached_q    <= reached_d;
      valid_q      <= valid_d;
      // Latch the speed at the last divider step
      if (state_q == ST_DIV && iter_q == '0) begin
        speed_q <= speed_sat;
      end
      // Hold the output word until taken
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Apply configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RAMP_STEP:     ramp_step_q     <= cfg_wdata_i[STEP_W-1:0];
          REG_RAMP_INTERVAL: ramp_interval_q <= cfg_wdata_i[INTV_W-1:0];
          REG_SPEED_WINDOW:  speed_window_q  <= cfg_wdata_i[WIN_W-1:0];
          REG_SPEED_SCALE:   speed_scale_q   <= cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: input capture, multiply/divide unit, output word
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tgt_duty_q <= s_axis_tdata[DUTY_BITS-1:0];
      tgt_dir_q  <= s_axis_tdata[DUTY_BITS];
      pulses_q   <= s_axis_tdata[DUTY_BITS+PULSE_W:DUTY_BITS+1];
    end
    if (state_q == ST_CALC) begin
      mul_cnt_q <= cnt_sum;
      divisor_q <= win_inc;
    end
    if (state_q == ST_MUL) begin
      quo_q  <= PROD_W'(speed_scale_q) * PROD_W'(mul_cnt_q);
      rem_q  <= '0;
      iter_q <= ITER_W'(PROD_W - 1);
    end
    if (state_q == ST_DIV) begin
      quo_q  <= {quo_q[PROD_W-2:0], q_bit};
      rem_q  <= rem_nx;
      iter_q <= iter_q - 1'b1;
    end
    if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {{(OUT_TDATA_W - OUT_W){1'b0}}, valid_q, speed_q, reached_q,
                     (phase_q != PH_START), drv_dir_q, duty_q};
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the DC motor duty ramp reverser: tick driver, result checker, duty/speed predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcmr_pkg::*;

  localparam int unsigned DUTY_MAX       = (1 << DUTY_BITS) - 1;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned HOLD_AFTER     = 300;
  localparam int unsigned TAIL_CYCLES    = 40;

  typedef struct {
    logic [DUTY_BITS-1:0] duty;
    logic                 dir;
    logic [PULSE_W-1:0]   pulses;
  } tick_t;

  typedef struct {
    logic [DUTY_BITS-1:0] duty;
    logic                 dir;
    logic                 enable;
    logic                 reached;
    logic [SPEED_W-1:0]   speed;
    logic                 fresh;
  } drive_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: target_duty, target_dir, encoder_pulses (lowest bit first)
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: duty_out, dir_out, drive_enable, ramp_reached, speed_value,
  //        speed_valid (lowest bit first)
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Pending ticks and the drive words they are expected to produce
  tick_t  tick_q[$];
  drive_t drive_q[$];

  // Predictor configuration
  int unsigned cfg_step, cfg_interval, cfg_window, cfg_scale;

  // Predictor state
  logic [1:0]            ctl_phase;
  int unsigned           duty_now;
  logic                  held_dir;
  logic                  drive_dir;
  int unsigned           ramp_tmr;
  logic [WIN_W-1:0]      win_tmr;
  logic [COUNT_BITS-1:0] pulse_sum;
  logic [SPEED_W-1:0]    speed_hold;

  // Bookkeeping
  int unsigned ticks_pushed, ticks_in, words_out, errors;
  int unsigned speed_updates, goals_hit, reversals, settings_used;
  int unsigned tx_gap, rx_gap, idle_cycles, hold_cnt;
  bit          hold_done;
  logic        hold_off;
  tick_t       tx_tick;

  dc_motor_duty_ramp_reverser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // Predictor: one ramp attempt toward goal; true when the goal is hit
  function automatic bit ramp_toward_goal(int unsigned goal, logic dir);
    bit hit;
    hit = 1'b0;
    if (ramp_tmr < cfg_interval) return 1'b0;
    if (duty_now < goal) begin
      if (duty_now + cfg_step >= goal) begin
        duty_now = goal;
        hit = 1'b1;
      end else begin
        duty_now = (duty_now + cfg_step) & DUTY_MAX;
      end
    end else if (duty_now <= goal + cfg_step) begin
      duty_now = goal;
      hit = 1'b1;
    end else begin
      duty_now -= cfg_step;
    end
    drive_dir = dir;
    ramp_tmr = 0;
    return hit;
  endfunction

  // Predictor: advance the controller and the speed meter by one tick
  function automatic drive_t predict_tick(tick_t t);
    drive_t          r;
    bit              hit;
    bit              fresh;
    longint unsigned q;
    hit = 1'b0;
    fresh = 1'b0;
    if (ramp_tmr < 255) ramp_tmr++;
    case (ctl_phase)
      PH_START: begin
        hit = ramp_toward_goal(32'(t.duty), held_dir);
        ctl_phase = PH_TRACK;
      end
      PH_TRACK: begin
        if (duty_now != t.duty) hit = ramp_toward_goal(32'(t.duty), held_dir);
        else if (held_dir != t.dir) ctl_phase = PH_DOWN;
      end
      PH_DOWN: begin
        hit = ramp_toward_goal(0, held_dir);
        if (hit) ctl_phase = PH_UP;
      end
      default: begin
        hit = ramp_toward_goal(32'(t.duty), !held_dir);
        if (hit) begin
          held_dir = !held_dir;
          ctl_phase = PH_TRACK;
          reversals++;
        end
      end
    endcase
    // Sum pulses and close the window when it is full
    pulse_sum = pulse_sum + COUNT_BITS'(t.pulses);
    win_tmr = win_tmr + 1'b1;
    if (win_tmr == '0) win_tmr = WIN_W'(1);
    if (win_tmr >= cfg_window) begin
      q = (64'(cfg_scale) * 64'(pulse_sum)) / 64'(win_tmr);
      speed_hold = (q > 64'hFFFF_FFFF) ? '1 : q[SPEED_W-1:0];
      pulse_sum = '0;
      win_tmr = '0;
      fresh = 1'b1;
      speed_updates++;
    end
    if (hit) goals_hit++;
    r.duty    = duty_now[DUTY_BITS-1:0];
    r.dir     = drive_dir;
    r.enable  = (ctl_phase != PH_START);
    r.reached = hit;
    r.speed   = speed_hold;
    r.fresh   = fresh;
    return r;
  endfunction

  function automatic void cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare one drive word against the oldest prediction
  function automatic void check_word(logic [OUT_TDATA_W-1:0] w);
    drive_t e;
    if (drive_q.size() == 0) begin
      $error("drive word 0x%0h arrived with no tick waiting", w);
      errors++;
      return;
    end
    e = drive_q.pop_front();
    cmp_field("duty_out", e.duty, w[DUTY_BITS-1:0]);
    cmp_field("dir_out", e.dir, w[DUTY_BITS]);
    cmp_field("drive_enable", e.enable, w[DUTY_BITS+1]);
    cmp_field("ramp_reached", e.reached, w[DUTY_BITS+2]);
    cmp_field("speed_value", e.speed, w[DUTY_BITS+3 +: SPEED_W]);
    cmp_field("speed_valid", e.fresh, w[DUTY_BITS+3+SPEED_W]);
  endfunction

  // Driver: feed ticks from the pending queue, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        drive_q.push_back(predict_tick(tx_tick));
        ticks_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0 && !hold_off) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          tx_tick = tick_q.pop_front();
          s_axis_tdata <= IN_TDATA_W'({tx_tick.pulses, tx_tick.dir, tx_tick.duty});
          s_axis_tvalid <= 1'b1;
          // Run without gaps on every third hundred ticks and during the hold-off
          if (hold_off || ((ticks_in / 100) % 3) == 2) tx_gap <= 0;
          else tx_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted words, throttle tready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_word(m_axis_tdata);
        words_out++;
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready) begin
        if (m_axis_tvalid && ((words_out / 100) % 4) != 1) begin
          rx_gap <= pick_gap();
          if (rx_gap != 0) m_axis_tready <= 1'b0;
        end
      end else if (rx_gap > 1) begin
        rx_gap <= rx_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap <= 0;
      end
    end
  end

  // Hold off the receiver once for a long stretch so the block backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_done <= 1'b1;
    end else if (!hold_done && ticks_in >= HOLD_AFTER) begin
      hold_cnt <= HOLD_CYCLES;
    end
  end
  assign hold_off = (hold_cnt != 0);

  // Watchdog on cycles where no word moves on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no word moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_tick(logic [DUTY_BITS-1:0] duty, logic dir, logic [PULSE_W-1:0] pulses);
    tick_t t;
    t.duty = duty;
    t.dir = dir;
    t.pulses = pulses;
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  task automatic push_run(logic [DUTY_BITS-1:0] duty, logic dir, int unsigned len);
    for (int unsigned k = 0; k < len; k++) push_tick(duty, dir, PULSE_W'($urandom_range(0, 15)));
  endtask

  // Mostly runs of a held target with random pulses, some per-tick noise
  task automatic queue_random(int unsigned n);
    int unsigned          left, len, pick, sel;
    logic [DUTY_BITS-1:0] duty;
    logic                 dir;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 40);
      if (len > left) len = left;
      pick = $urandom_range(0, 9);
      sel = $urandom_range(0, 3);
      duty = (sel == 0) ? '0 : (sel == 1) ? DUTY_BITS'(DUTY_MAX) : DUTY_BITS'($urandom);
      dir = 1'($urandom_range(0, 1));
      for (int unsigned k = 0; k < len; k++) begin
        if (pick >= 8) begin
          duty = DUTY_BITS'($urandom);
          dir = 1'($urandom_range(0, 1));
        end
        push_tick(duty, dir, PULSE_W'($urandom_range(0, 15)));
      end
      left -= len;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RAMP_STEP:     cfg_step = 32'(val[STEP_W-1:0]);
      REG_RAMP_INTERVAL: cfg_interval = 32'(val[INTV_W-1:0]);
      REG_SPEED_WINDOW:  cfg_window = 32'(val[WIN_W-1:0]);
      default:           cfg_scale = 32'(val[SCALE_W-1:0]);
    endcase
  endtask

  task automatic set_regs(int unsigned step, int unsigned intv, int unsigned win,
                          int unsigned scale);
    write_reg(REG_RAMP_STEP, CFG_W'(step));
    write_reg(REG_RAMP_INTERVAL, CFG_W'(intv));
    write_reg(REG_SPEED_WINDOW, CFG_W'(win));
    write_reg(REG_SPEED_SCALE, CFG_W'(scale));
    settings_used++;
  endtask

  // Wait until every queued tick is taken and every drive word checked
  task automatic drain();
    while (ticks_in != ticks_pushed || drive_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    cfg_step = 32'(RST_RAMP_STEP);
    cfg_interval = 32'(RST_RAMP_INTERVAL);
    cfg_window = 32'(RST_SPEED_WINDOW);
    cfg_scale = 32'(RST_SPEED_SCALE);
    ctl_phase = PH_START;
    duty_now = 0;
    held_dir = 1'b0;
    drive_dir = 1'b0;
    ramp_tmr = 255;
    win_tmr = '0;
    pulse_sum = '0;
    speed_hold = '0;
    settings_used = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Reset settings: first step at once with duty already at goal, field extremes
    push_tick('0, 1'b0, 4'hF);
    push_tick(DUTY_BITS'(DUTY_MAX), 1'b1, 4'h0);
    push_tick(DUTY_BITS'(DUTY_MAX), 1'b0, 4'hF);
    push_tick(DUTY_BITS'(512), 1'b1, 4'h5);
    push_tick('0, 1'b1, 4'hA);
    drain();

    // Fast ramp: full reversal, clamp on the way down, reversal at zero duty
    set_regs(300, 1, 3, 7);
    push_run(DUTY_BITS'(DUTY_MAX), 1'b0, 5);
    push_run(DUTY_BITS'(DUTY_MAX), 1'b1, 10);
    push_run('0, 1'b1, 5);
    push_run('0, 1'b0, 3);
    push_run(DUTY_BITS'(700), 1'b0, 3);
    drain();

    // Extremes: widest step, shortest interval and window, largest scale
    set_regs(DUTY_MAX, 1, 1, 65535);
    queue_random(200);
    drain();

    // Extremes: smallest nonzero step, longest interval and window, zero scale
    set_regs(1, 255, 65535, 0);
    queue_random(150);
    drain();

    // Zero step, zero interval, zero window
    set_regs(0, 0, 0, 12345);
    queue_random(80);
    drain();

    // Random settings with short intervals so reversals complete
    repeat (4) begin
      set_regs($urandom_range(1, 400), $urandom_range(1, 6), $urandom_range(1, 40),
               $urandom_range(0, 65535));
      queue_random(190);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d ticks and checked %0d drive words over %0d register settings.",
             ticks_in, words_out, settings_used);
    $display("Saw %0d speed updates, %0d ramp goals reached, %0d direction reversals.",
             speed_updates, goals_hit, reversals);
    if (errors == 0 && drive_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
